// File: design/tsfs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfs_pkg: shared definitions for the two-stream frame synchronizer
// Request and response payloads, request and status codes, default sizes.
// ----------------------------------------------------------------------------
package tsfs_pkg;

   // Fixed field widths of the request and response payloads.
   localparam int SEQ_W    = 32;
   localparam int HANDLE_W = 16;
   localparam int CODE_W   = 2;

   // Defaults for the top-level parameters.
   localparam int FIFO_DEPTH_DEF  = 16;
   localparam int HANDLE_BITS_DEF = 16;

   // Request codes.
   localparam logic [CODE_W-1:0] REQ_PUSH_COLOR = 2'd0;
   localparam logic [CODE_W-1:0] REQ_PUSH_DEPTH = 2'd1;
   localparam logic [CODE_W-1:0] REQ_GET_PAIR   = 2'd2;

   // Response status codes.
   localparam logic [CODE_W-1:0] ST_PUSHED = 2'd0;
   localparam logic [CODE_W-1:0] ST_FULL   = 2'd1;
   localparam logic [CODE_W-1:0] ST_FOUND  = 2'd2;
   localparam logic [CODE_W-1:0] ST_NONE   = 2'd3;

   typedef struct packed {
      logic [CODE_W-1:0]   req_type;
      logic [SEQ_W-1:0]    seq_id;
      logic [HANDLE_W-1:0] frame_handle;
   } req_payload_type;

   typedef struct packed {
      logic [CODE_W-1:0]   status;
      logic [SEQ_W-1:0]    pair_seq_id;
      logic [HANDLE_W-1:0] color_handle;
      logic [HANDLE_W-1:0] depth_handle;
   } rsp_payload_type;

endpackage

// File: design/two_stream_frame_synchronizer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stream_frame_synchronizer: pairs colour and depth frames by sequence id
// Two circular record FIFOs, a small sequencer and one shared comparator.
// ----------------------------------------------------------------------------
// A push request is answered in the cycle after it is accepted. A get request
// walks both FIFOs through one shared sequence-number comparator and the
// registered read ports of the two record memories. A wait state lets the
// head reads settle first and after every pop. Each outer pass checks the
// counts, discards colour heads below the depth head, then depth heads below
// the colour head, and pops a matched pair. Every pass pops at least one
// record, so a get always ends. The block takes one request at a time;
// req_stall stays high from acceptance until the response has been taken.
// Records are never cleared: only entries counted as valid are read.
module two_stream_frame_synchronizer
   import tsfs_pkg::*;
#(
   parameter int FIFO_DEPTH  = FIFO_DEPTH_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data
);

   // Stored handle width: the request carries at most HANDLE_W bits.
   localparam int HB    = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;
   localparam int REC_W = SEQ_W + HB;
   localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_WAIT = 6'b000010,
      S_TOP  = 6'b000100,
      S_CCMP = 6'b001000,
      S_DCMP = 6'b010000,
      S_RESP = 6'b100000
   } state_type;

   state_type       state_ff, state_in;
   state_type       ret_ff, ret_in;
   logic [PTR_W-1:0] c_head_ff, c_head_in, d_head_ff, d_head_in;
   logic [CNT_W-1:0] c_count_ff, c_count_in, d_count_ff, d_count_in;
   rsp_payload_type  rsp_ff, rsp_in;

   logic [REC_W-1:0] c_mem_ff [FIFO_DEPTH];
   logic [REC_W-1:0] d_mem_ff [FIFO_DEPTH];
   logic [REC_W-1:0] c_rd_ff, d_rd_ff;

   logic             c_we, d_we;
   logic [PTR_W-1:0] c_tail, d_tail;
   logic [REC_W-1:0] wr_rec;

   logic [SEQ_W-1:0] c_seq, d_seq, cmp_a, cmp_b;
   logic             cmp_lt, cmp_eq;
   logic             req_accept, c_full, d_full;

   // Wrap helper for a head or tail index.
   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      logic [PTR_W-1:0] r;
      if (p == PTR_W'(FIFO_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_W'(1);
      end
      return r;
   endfunction

   // Tail index: head plus count stays below twice the depth.
   function automatic logic [PTR_W-1:0] tail_of(input logic [PTR_W-1:0] h,
                                                 input logic [CNT_W-1:0] n);
      logic [PTR_W+CNT_W-1:0] s;
      s = (PTR_W+CNT_W)'(h) + (PTR_W+CNT_W)'(n);
      if (s >= (PTR_W+CNT_W)'(FIFO_DEPTH)) begin
         s = s - (PTR_W+CNT_W)'(FIFO_DEPTH);
      end
      return s[PTR_W-1:0];
   endfunction

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = (state_ff == S_RESP);
   assign rsp_data   = rsp_ff;

   assign c_tail = tail_of(c_head_ff, c_count_ff);
   assign d_tail = tail_of(d_head_ff, d_count_ff);
   assign c_full = (c_count_ff >= CNT_W'(FIFO_DEPTH));
   assign d_full = (d_count_ff >= CNT_W'(FIFO_DEPTH));
   assign wr_rec = {req_data.seq_id, req_data.frame_handle[HB-1:0]};

   assign c_seq = c_rd_ff[REC_W-1:HB];
   assign d_seq = d_rd_ff[REC_W-1:HB];

   // Shared comparator: colour against depth, or depth against colour.
   always_comb begin
      if (state_ff == S_DCMP) begin
         cmp_a = d_seq;
         cmp_b = c_seq;
      end else begin
         cmp_a = c_seq;
         cmp_b = d_seq;
      end
      cmp_lt = (cmp_a < cmp_b);
      cmp_eq = (cmp_a == cmp_b);
   end

   // Record memories: one write at the tail, one registered read at the head.
   always_ff @(posedge clock) begin
      if (c_we) begin
         c_mem_ff[c_tail] <= wr_rec;
      end
      c_rd_ff <= c_mem_ff[c_head_ff];
   end

   always_ff @(posedge clock) begin
      if (d_we) begin
         d_mem_ff[d_tail] <= wr_rec;
      end
      d_rd_ff <= d_mem_ff[d_head_ff];
   end

   // Sequencer for pushes and the matching walk.
   always_comb begin
      state_in   = state_ff;
      ret_in     = ret_ff;
      c_head_in  = c_head_ff;
      d_head_in  = d_head_ff;
      c_count_in = c_count_ff;
      d_count_in = d_count_ff;
      rsp_in     = rsp_ff;
      c_we       = 1'b0;
      d_we       = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               rsp_in = '{status: ST_NONE, default: '0};
               state_in = S_RESP;
               case (req_data.req_type)
                  REQ_PUSH_COLOR: begin
                     if (c_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status = ST_PUSHED;
                        c_we = 1'b1;
                        c_count_in = c_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_PUSH_DEPTH: begin
                     if (d_full) begin
                        rsp_in.status = ST_FULL;
                     end else begin
                        rsp_in.status = ST_PUSHED;
                        d_we = 1'b1;
                        d_count_in = d_count_ff + CNT_W'(1);
                     end
                  end
                  REQ_GET_PAIR: begin
                     state_in = S_WAIT;
                     ret_in   = S_TOP;
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end
         end
         // Let the head reads settle after a pop or when a get is accepted.
         S_WAIT: begin
            state_in = ret_ff;
         end
         // Outer pass: both FIFOs must hold more than one record.
         S_TOP: begin
            if ((c_count_ff > CNT_W'(1)) && (d_count_ff > CNT_W'(1))) begin
               state_in = S_CCMP;
            end else begin
               state_in = S_RESP;
            end
         end
         // Discard colour heads numbered below the depth head.
         S_CCMP: begin
            if (c_count_ff == '0) begin
               state_in = S_RESP;
            end else if (cmp_lt) begin
               c_head_in  = ptr_inc(c_head_ff);
               c_count_in = c_count_ff - CNT_W'(1);
               ret_in     = S_CCMP;
               state_in   = S_WAIT;
            end else begin
               state_in = S_DCMP;
            end
         end
         // Discard depth heads below the colour head, then try a match.
         S_DCMP: begin
            if (d_count_ff == '0) begin
               state_in = S_RESP;
            end else if (cmp_lt) begin
               d_head_in  = ptr_inc(d_head_ff);
               d_count_in = d_count_ff - CNT_W'(1);
               ret_in     = S_DCMP;
               state_in   = S_WAIT;
            end else if (cmp_eq) begin
               rsp_in.status       = ST_FOUND;
               rsp_in.pair_seq_id  = c_seq;
               rsp_in.color_handle = HANDLE_W'(c_rd_ff[HB-1:0]);
               rsp_in.depth_handle = HANDLE_W'(d_rd_ff[HB-1:0]);
               c_head_in  = ptr_inc(c_head_ff);
               c_count_in = c_count_ff - CNT_W'(1);
               d_head_in  = ptr_inc(d_head_ff);
               d_count_in = d_count_ff - CNT_W'(1);
               ret_in     = S_TOP;
               state_in   = S_WAIT;
            end else begin
               state_in = S_TOP;
            end
         end
         S_RESP: begin
            if (!rsp_stall) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         ret_ff     <= S_TOP;
         c_head_ff  <= '0;
         d_head_ff  <= '0;
         c_count_ff <= '0;
         d_count_ff <= '0;
      end else begin
         state_ff   <= state_in;
         ret_ff     <= ret_in;
         c_head_ff  <= c_head_in;
         d_head_ff  <= d_head_in;
         c_count_ff <= c_count_in;
         d_count_ff <= d_count_in;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

// File: design/tsfs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsfs_checker: port-level checks for the two-stream frame synchronizer
// Watches the request and response channels and is bound to the top level.
// ----------------------------------------------------------------------------
module tsfs_checker
   import tsfs_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_stall,
   input req_payload_type req_data,
   input logic            rsp_valid,
   input logic            rsp_stall,
   input rsp_payload_type rsp_data
);

   // A stalled response stays up with the same payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   // No new request is taken while a response is pending.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while a response is pending");

   // A push request is answered in the next cycle with a push status.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall &&
      (req_data.req_type == REQ_PUSH_COLOR || req_data.req_type == REQ_PUSH_DEPTH)
      |=> rsp_valid && (rsp_data.status == ST_PUSHED || rsp_data.status == ST_FULL))
      else $error("push request not answered with a push status");

   // Only a found pair carries nonzero pair fields.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != ST_FOUND |->
      rsp_data.pair_seq_id == '0 && rsp_data.color_handle == '0 &&
      rsp_data.depth_handle == '0)
      else $error("pair fields nonzero without a found pair");

endmodule

bind two_stream_frame_synchronizer tsfs_checker u_tsfs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/two_stream_frame_synchronizer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_stream_frame_synchronizer_tb: self-checking testbench for the frame pairer
// Sends colour pushes, depth pushes, pair lookups and undefined codes with random pacing on both
// channels. A behavioral copy of the two frame queues predicts every response,
// and each response is checked field by field against that prediction.
// ----------------------------------------------------------------------------
module two_stream_frame_synchronizer_tb;
   import tsfs_pkg::*;

   localparam int FIFO_DEPTH  = FIFO_DEPTH_DEF;
   localparam int HANDLE_BITS = HANDLE_BITS_DEF;
   localparam logic [HANDLE_W-1:0] HANDLE_MASK = {HANDLE_W{1'b1}} >> (HANDLE_W - HANDLE_BITS);

   // The request code that the block must answer without touching its queues.
   localparam logic [CODE_W-1:0] REQ_UNDEFINED = 2'd3;

   localparam int COLOR_SIDE      = 0;
   localparam int DEPTH_SIDE      = 1;
   localparam int TARGET_REQUESTS = 850;
   localparam int RECEIVER_HOLD   = 200;
   localparam int DRAIN_CYCLES    = 100;
   localparam int IDLE_LIMIT      = 2000;

   typedef struct packed {
      logic [SEQ_W-1:0]    seq_id;
      logic [HANDLE_W-1:0] handle;
   } frame_record_type;

   // Behavioral copy of both frame queues plus the list of awaited responses.
   class frame_pair_scoreboard;
      frame_record_type records[2][FIFO_DEPTH];
      int unsigned      head[2];
      int unsigned      count[2];
      rsp_payload_type  awaited_responses[$];
      int unsigned      mismatches;
      int unsigned      stored;
      int unsigned      dropped;
      int unsigned      matched;
      int unsigned      unmatched;

      function frame_record_type front(int side);
         return records[side][head[side]];
      endfunction

      function void pop(int side);
         head[side] = (head[side] + 1) % FIFO_DEPTH;
         count[side]--;
      endfunction

      function bit is_full(int side);
         return count[side] == FIFO_DEPTH;
      endfunction

      // Updates the queues for an accepted request and queues its response.
      function void note_request(req_payload_type req);
         rsp_payload_type  answer;
         int               side;
         frame_record_type color_rec;
         frame_record_type depth_rec;
         answer = '0;
         answer.status = ST_NONE;
         if (req.req_type == REQ_PUSH_COLOR || req.req_type == REQ_PUSH_DEPTH) begin
            side = (req.req_type == REQ_PUSH_COLOR) ? COLOR_SIDE : DEPTH_SIDE;
            if (is_full(side)) begin
               answer.status = ST_FULL;
            end else begin
               records[side][(head[side] + count[side]) % FIFO_DEPTH] =
                  '{seq_id: req.seq_id, handle: req.frame_handle & HANDLE_MASK};
               count[side]++;
               answer.status = ST_PUSHED;
            end
         end else if (req.req_type == REQ_GET_PAIR) begin
            // Walk both queues while each keeps more than one frame.
            while (count[COLOR_SIDE] > 1 && count[DEPTH_SIDE] > 1) begin
               while (count[COLOR_SIDE] > 0 &&
                      front(COLOR_SIDE).seq_id < front(DEPTH_SIDE).seq_id)
                  pop(COLOR_SIDE);
               if (count[COLOR_SIDE] == 0)
                  break;
               while (count[DEPTH_SIDE] > 0 &&
                      front(DEPTH_SIDE).seq_id < front(COLOR_SIDE).seq_id)
                  pop(DEPTH_SIDE);
               if (count[DEPTH_SIDE] == 0)
                  break;
               color_rec = front(COLOR_SIDE);
               depth_rec = front(DEPTH_SIDE);
               if (color_rec.seq_id != depth_rec.seq_id)
                  continue;
               answer.status       = ST_FOUND;
               answer.pair_seq_id  = color_rec.seq_id;
               answer.color_handle = color_rec.handle;
               answer.depth_handle = depth_rec.handle;
               pop(COLOR_SIDE);
               pop(DEPTH_SIDE);
            end
         end
         awaited_responses.push_back(answer);
      endfunction

      // Compares an accepted response with the oldest awaited one.
      function void check_response(rsp_payload_type got);
         rsp_payload_type want;
         if (awaited_responses.size() == 0) begin
            $error("Response without a pending request: status %0d, pair_seq_id 0x%08h",
                   got.status, got.pair_seq_id);
            mismatches++;
            return;
         end
         want = awaited_responses.pop_front();
         if (got.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            mismatches++;
         end
         if (got.pair_seq_id !== want.pair_seq_id) begin
            $error("pair_seq_id: expected 0x%08h, actual 0x%08h",
                   want.pair_seq_id, got.pair_seq_id);
            mismatches++;
         end
         if (got.color_handle !== want.color_handle) begin
            $error("color_handle: expected 0x%04h, actual 0x%04h",
                   want.color_handle, got.color_handle);
            mismatches++;
         end
         if (got.depth_handle !== want.depth_handle) begin
            $error("depth_handle: expected 0x%04h, actual 0x%04h",
                   want.depth_handle, got.depth_handle);
            mismatches++;
         end
         case (want.status)
            ST_PUSHED: stored++;
            ST_FULL:   dropped++;
            ST_FOUND:  matched++;
            default:   unmatched++;
         endcase
      endfunction
   endclass

   logic            clock     = 1'b0;
   logic            reset     = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data  = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;

   frame_pair_scoreboard scoreboard;
   logic [SEQ_W-1:0]     next_frame    = '0;
   int unsigned          requests_sent = 0;
   int unsigned          zero_gap_run  = 0;
   int unsigned          idle_cycles   = 0;
   bit                   hold_receiver = 1'b0;

   two_stream_frame_synchronizer #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .HANDLE_BITS (HANDLE_BITS)
   ) i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #10 clock = ~clock;

   // Random frame handle over the whole request field.
   function automatic logic [HANDLE_W-1:0] random_handle();
      return HANDLE_W'($urandom_range(0, 16'hFFFF));
   endfunction

   // Offers one request after a random gap and holds it until it is taken.
   task automatic offer(input logic [CODE_W-1:0] code, input logic [SEQ_W-1:0] seq,
                        input logic [HANDLE_W-1:0] handle);
      req_payload_type req;
      int unsigned     gap;
      int unsigned     pick;
      req  = '{req_type: code, seq_id: seq, frame_handle: handle};
      pick = $urandom_range(0, 19);
      if (zero_gap_run > 0) begin
         zero_gap_run--;
         gap = 0;
      end else if (pick < 2) begin
         zero_gap_run = $urandom_range(10, 40);
         gap = 0;
      end else if (pick < 9) begin
         gap = 0;
      end else if (pick < 18) begin
         gap = $urandom_range(1, 3);
      end else if (pick < 19) begin
         gap = $urandom_range(4, 10);
      end else begin
         gap = $urandom_range(15, 40);
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= req;
      do @(posedge clock); while (req_stall !== 1'b0);
      scoreboard.note_request(req);
      if (code != REQ_UNDEFINED)
         requests_sent++;
   endtask

   // Stops sending until every awaited response has come back.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (scoreboard.awaited_responses.size() != 0);
   endtask

   // Response side: checks every response at the edge that takes it.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         scoreboard.check_response(rsp_data);
   end

   // Receiver pacing: short stalls, long stalls, quiet stretches and one long hold.
   initial begin : receiver_pacing
      int unsigned stall_len;
      int unsigned ready_len;
      int unsigned pick;
      wait (reset == 1'b0);
      forever begin
         pick = $urandom_range(0, 19);
         if (hold_receiver) begin
            hold_receiver = 1'b0;
            stall_len = RECEIVER_HOLD;
            ready_len = 1;
         end else if (pick < 5) begin
            stall_len = 0;
            ready_len = $urandom_range(20, 80);
         end else if (pick < 18) begin
            stall_len = $urandom_range(0, 3);
            ready_len = $urandom_range(1, 4);
         end else begin
            stall_len = $urandom_range(15, 60);
            ready_len = $urandom_range(1, 3);
         end
         if (stall_len > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_len) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         repeat (ready_len) @(posedge clock);
      end
   end

   // Counts cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_valid && req_stall === 1'b0) || (rsp_valid === 1'b1 && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin : watchdog
      wait (idle_cycles >= IDLE_LIMIT);
      $display("Watchdog: nothing moved on either channel for %0d cycles.", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      int unsigned       burst;
      int unsigned       pick;
      int unsigned       frames;
      int                side;
      bit                lag_depth;
      bit                color_first;
      logic [CODE_W-1:0] code;
      logic [SEQ_W-1:0]  late_depth[$];
      scoreboard = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: empty queues, undefined code, single-entry queues,
      // a first match, then a colour queue filled up to a drop.
      offer(REQ_GET_PAIR, 32'hFFFF_FFFF, 16'hFFFF);
      offer(REQ_UNDEFINED, 32'hFFFF_FFFF, 16'hFFFF);
      offer(REQ_PUSH_COLOR, 32'h0, 16'h0000);
      offer(REQ_PUSH_DEPTH, 32'h0, 16'hFFFF);
      offer(REQ_GET_PAIR, 32'h0, 16'h0000);
      offer(REQ_PUSH_COLOR, 32'h1, 16'hFFFF);
      offer(REQ_PUSH_DEPTH, 32'h1, 16'h0000);
      offer(REQ_GET_PAIR, 32'h0, 16'h0000);
      for (int n = 2; n <= FIFO_DEPTH; n++)
         offer(REQ_PUSH_COLOR, n, (n % 2 == 1) ? 16'hAAAA : 16'h5555);
      offer(REQ_PUSH_COLOR, 32'hFFFF_FFFF, 16'hFFFF);
      offer(REQ_GET_PAIR, 32'hFFFF_FFFF, 16'hFFFF);

      // Random part: mostly frame streams in order, some floods and noise.
      next_frame = $urandom_range(32'h0000_0100, 32'h3FFF_FFFF);
      burst = 0;
      while (requests_sent < TARGET_REQUESTS) begin
         if (burst == 3)
            hold_receiver = 1'b1;
         if (burst == 10 || $urandom_range(0, 29) == 0)
            wait_for_drain();
         pick = $urandom_range(0, 19);
         if (pick < 14) begin
            // Both streams advance together, with skipped frames and a
            // lagging depth stream now and then.
            frames    = $urandom_range(2, 10);
            lag_depth = ($urandom_range(0, 3) == 0);
            repeat (frames) begin
               next_frame += $urandom_range(1, 3);
               color_first = 1'($urandom_range(0, 1));
               if (color_first && $urandom_range(0, 7) != 0)
                  offer(REQ_PUSH_COLOR, next_frame, random_handle());
               if ($urandom_range(0, 7) != 0) begin
                  if (lag_depth)
                     late_depth.push_back(next_frame);
                  else
                     offer(REQ_PUSH_DEPTH, next_frame, random_handle());
               end
               if (!color_first && $urandom_range(0, 7) != 0)
                  offer(REQ_PUSH_COLOR, next_frame, random_handle());
               if ($urandom_range(0, 2) == 0)
                  offer(REQ_GET_PAIR, $urandom(), random_handle());
            end
            while (late_depth.size() != 0)
               offer(REQ_PUSH_DEPTH, late_depth.pop_front(), random_handle());
            offer(REQ_GET_PAIR, $urandom(), random_handle());
         end else if (pick < 16) begin
            // One stream runs ahead until its queue overflows.
            code = ($urandom_range(0, 1) == 1) ? REQ_PUSH_DEPTH : REQ_PUSH_COLOR;
            side = (code == REQ_PUSH_COLOR) ? COLOR_SIDE : DEPTH_SIDE;
            repeat ($urandom_range(FIFO_DEPTH + 1, FIFO_DEPTH + 4)) begin
               if (scoreboard.is_full(side)) begin
                  offer(code, $urandom(), random_handle());
               end else begin
                  next_frame += 1;
                  offer(code, next_frame, random_handle());
               end
            end
            offer(REQ_GET_PAIR, $urandom(), random_handle());
         end else begin
            // Noise: any code, with pushes near the current frame number.
            repeat ($urandom_range(3, 8)) begin
               code = CODE_W'($urandom_range(0, 3));
               if (code == REQ_PUSH_COLOR || code == REQ_PUSH_DEPTH) begin
                  side = (code == REQ_PUSH_COLOR) ? COLOR_SIDE : DEPTH_SIDE;
                  if (scoreboard.is_full(side))
                     offer(code, $urandom(), random_handle());
                  else
                     offer(code, next_frame + $urandom_range(0, 4) - 3,
                           random_handle());
               end else begin
                  offer(code, $urandom(), random_handle());
               end
            end
         end
         burst++;
      end

      // Let the last responses arrive, then give the block time to misbehave.
      wait_for_drain();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests: %0d frames stored, %0d pushes dropped on a full queue.",
               requests_sent, scoreboard.stored, scoreboard.dropped);
      $display("Lookups returned %0d synchronized pairs; %0d responses carried no pair.",
               scoreboard.matched, scoreboard.unmatched);
      if (scoreboard.mismatches == 0 && scoreboard.awaited_responses.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: filelist.f
design/tsfs_pkg.sv
design/two_stream_frame_synchronizer.sv
design/tsfs_checker.sv
tb/two_stream_frame_synchronizer_tb.sv
